// File: src/acrp_pkg.sv
// acrp_pkg: shared types and codes for the decoder configuration record parser
// no dependencies

package acrp_pkg;

  typedef enum logic [3:0] {
    KIND_VERSION    = 4'd0,
    KIND_PROFILE    = 4'd1,
    KIND_COMPAT     = 4'd2,
    KIND_LEVEL      = 4'd3,
    KIND_NAL_SIZE   = 4'd4,
    KIND_SPS_COUNT  = 4'd5,
    KIND_SPS_LENGTH = 4'd6,
    KIND_SPS_BYTE   = 4'd7,
    KIND_PPS_COUNT  = 4'd8,
    KIND_PPS_LENGTH = 4'd9,
    KIND_PPS_BYTE   = 4'd10,
    KIND_IGNORED    = 4'd11
  } field_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EARLY    = 2'd1,
    STATUS_TRAILING = 2'd2
  } status_t;

  localparam logic [7:0] SPS_COUNT_MASK = 8'h1F;
  localparam logic [7:0] NAL_SIZE_MASK  = 8'h03;

  // registered input item
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       record_end;
  } item_t;

  // one step's result
  typedef struct packed {
    logic        emit;
    field_kind_t field_kind;
    logic [15:0] field_value;
    logic [7:0]  set_index;
    logic        last_of_set;
    logic        record_done;
    status_t     status;
  } result_t;

endpackage

// File: src/acrp_in_reg.sv
// acrp_in_reg: input register stage holding one accepted byte
// depends on acrp_pkg

module acrp_in_reg
  import acrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_ready,
  input  logic [7:0] data_byte,
  input  logic       record_end,
  input  logic       advance,
  output item_t      item
);

  logic       held;
  logic [7:0] byte_q;
  logic       end_q;

  assign data_ready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (data_ready) begin
      held <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && data_ready) begin
      byte_q <= data_byte;
      end_q  <= record_end;
    end
  end

  assign item.valid      = held;
  assign item.data_byte  = byte_q;
  assign item.record_end = end_q;

endmodule

// File: src/acrp_parser.sv
// acrp_parser: record state and per-byte field decode
// depends on acrp_pkg

module acrp_parser
  import acrp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t result
);

  typedef enum logic [3:0] {
    PH_VERSION, PH_PROFILE, PH_COMPAT, PH_LEVEL, PH_NALSIZE, PH_SPSCOUNT,
    PH_SPSHI, PH_SPSLO, PH_SPSDATA, PH_PPSCOUNT, PH_PPSHI, PH_PPSLO,
    PH_PPSDATA, PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  sets_left, sets_left_next;
  logic [7:0]  current_set, current_set_next;
  logic [7:0]  length_high, length_high_next;

  logic [7:0]  b;
  logic        complete;
  logic        is_pps;
  logic [15:0] len_word;
  logic [15:0] bytes_dec;
  logic [7:0]  sets_dec;

  assign b         = item.data_byte;
  assign len_word  = {length_high, b};
  assign bytes_dec = bytes_left - 16'd1;
  assign sets_dec  = sets_left - 8'd1;

  always_comb begin
    phase_next         = phase;
    bytes_left_next    = bytes_left;
    sets_left_next     = sets_left;
    current_set_next   = current_set;
    length_high_next   = length_high;
    complete           = 1'b0;
    is_pps             = 1'b0;
    result.emit        = 1'b1;
    result.field_kind  = KIND_IGNORED;
    result.field_value = {8'd0, b};
    result.set_index   = 8'd0;
    result.last_of_set = 1'b0;
    result.record_done = item.record_end;
    result.status      = STATUS_OK;

    case (phase)
      PH_VERSION: begin
        result.field_kind = KIND_VERSION;
        phase_next = PH_PROFILE;
      end
      PH_PROFILE: begin
        result.field_kind = KIND_PROFILE;
        phase_next = PH_COMPAT;
      end
      PH_COMPAT: begin
        result.field_kind = KIND_COMPAT;
        phase_next = PH_LEVEL;
      end
      PH_LEVEL: begin
        result.field_kind = KIND_LEVEL;
        phase_next = PH_NALSIZE;
      end
      PH_NALSIZE: begin
        result.field_kind  = KIND_NAL_SIZE;
        result.field_value = {8'd0, (b & NAL_SIZE_MASK) + 8'd1};
        phase_next = PH_SPSCOUNT;
      end
      PH_SPSCOUNT: begin
        result.field_kind  = KIND_SPS_COUNT;
        result.field_value = {8'd0, b & SPS_COUNT_MASK};
        sets_left_next   = b & SPS_COUNT_MASK;
        current_set_next = 8'd0;
        phase_next = ((b & SPS_COUNT_MASK) == 8'd0) ? PH_PPSCOUNT : PH_SPSHI;
      end
      PH_PPSCOUNT: begin
        result.field_kind = KIND_PPS_COUNT;
        sets_left_next   = b;
        current_set_next = 8'd0;
        if (b == 8'd0) begin
          complete = 1'b1;
        end else begin
          phase_next = PH_PPSHI;
        end
      end
      PH_SPSHI, PH_PPSHI: begin
        length_high_next = b;
        result.emit = 1'b0;
        phase_next = (phase == PH_SPSHI) ? PH_SPSLO : PH_PPSLO;
      end
      PH_SPSLO, PH_PPSLO, PH_SPSDATA, PH_PPSDATA: begin
        is_pps = (phase == PH_PPSLO) || (phase == PH_PPSDATA);
        result.set_index = current_set;
        if ((phase == PH_SPSLO) || (phase == PH_PPSLO)) begin
          result.field_kind  = is_pps ? KIND_PPS_LENGTH : KIND_SPS_LENGTH;
          result.field_value = len_word;
          bytes_left_next    = len_word;
          phase_next = is_pps ? PH_PPSDATA : PH_SPSDATA;
        end else begin
          result.field_kind = is_pps ? KIND_PPS_BYTE : KIND_SPS_BYTE;
          bytes_left_next   = bytes_dec;
          result.last_of_set = (bytes_dec == 16'd0);
        end
        // set finished
        if (bytes_left_next == 16'd0) begin
          sets_left_next   = sets_dec;
          current_set_next = current_set + 8'd1;
          if (sets_dec != 8'd0) begin
            phase_next = is_pps ? PH_PPSHI : PH_SPSHI;
          end else begin
            current_set_next = 8'd0;
            if (is_pps) begin
              complete = 1'b1;
            end else begin
              phase_next = PH_PPSCOUNT;
            end
          end
        end
      end
      default: begin
        result.status = STATUS_TRAILING;
      end
    endcase

    if ((result.status == STATUS_OK) && item.record_end && !complete) begin
      result.status = STATUS_EARLY;
    end

    if (item.record_end) begin
      result.emit      = 1'b1;
      phase_next       = PH_VERSION;
      bytes_left_next  = 16'd0;
      sets_left_next   = 8'd0;
      current_set_next = 8'd0;
      length_high_next = 8'd0;
    end else if (complete) begin
      phase_next = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_VERSION;
      bytes_left  <= 16'd0;
      sets_left   <= 8'd0;
      current_set <= 8'd0;
      length_high <= 8'd0;
    end else if (fire) begin
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      sets_left   <= sets_left_next;
      current_set <= current_set_next;
      length_high <= length_high_next;
    end
  end

`ifndef SYNTHESIS
  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && item.record_end |=> phase == PH_VERSION && sets_left == 8'd0)
    else $error("record end did not restart the parser");

  a_done_trailing: assert property (@(posedge clk) disable iff (rst)
    fire && phase == PH_DONE |-> result.status == STATUS_TRAILING && result.emit)
    else $error("byte after complete record not flagged");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    fire && result.last_of_set |->
      result.field_kind == KIND_SPS_BYTE || result.field_kind == KIND_PPS_BYTE)
    else $error("last of set on a non data byte");

  a_quiet_only_hi: assert property (@(posedge clk) disable iff (rst)
    fire && !result.emit |=> phase == PH_SPSLO || phase == PH_PPSLO)
    else $error("silent byte outside a length high byte");
`endif

endmodule

// File: src/avc_config_record_parser.sv
// avc_config_record_parser: top level, input stage, parser and result register
// depends on acrp_pkg, acrp_in_reg, acrp_parser

// Parses an H.264 decoder configuration record fed one byte per item and
// delivers one result item for each completed field (the high byte of a
// length gives none unless it ends the record). Throughput is one byte per
// cycle while no result waits on result_ready. The result item becomes
// valid once its byte has been taken into the input register at the accept
// edge and the per-byte state update has then loaded the result register.
// A result waiting on result_ready holds back the state update for every
// byte, including the silent ones. The input register then takes one more
// byte if it is empty, and after that the input stalls.

module avc_config_record_parser
  import acrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        record_end,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [3:0]  field_kind,
  output logic [15:0] field_value,
  output logic [7:0]  set_index,
  output logic        last_of_set,
  output logic        record_done,
  output logic [1:0]  status
);

  item_t   item;
  result_t step;
  logic    fire;
  result_t held;

  assign fire = item.valid && (!result_valid || result_ready);

  acrp_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_ready (data_ready),
    .data_byte  (data_byte),
    .record_end (record_end),
    .advance    (fire),
    .item       (item)
  );

  acrp_parser u_parse (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= step.emit;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step.emit) begin
      held <= step;
    end
  end

  assign field_kind  = held.field_kind;
  assign field_value = held.field_value;
  assign set_index   = held.set_index;
  assign last_of_set = held.last_of_set;
  assign record_done = held.record_done;
  assign status      = held.status;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !fire)
    else $error("pending result overwritten");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    fire && step.emit |=> result_valid)
    else $error("emitted result not presented");

  a_status_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && held.status == STATUS_EARLY |-> held.record_done)
    else $error("early end without record done");
`endif

endmodule
